[sv/sdz_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdz_pkg
// shared constants and types for the stick deadzone scaler
// ----------------------------------------------------------------------------
package sdz_pkg;

    typedef enum logic [1:0] {
        MODE_NONE        = 2'd0,
        MODE_INDEPENDENT = 2'd1,
        MODE_CIRCULAR    = 2'd2,
        MODE_UNUSED      = 2'd3
    } t_mode;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_FULL     = 2'd1;
    localparam logic [1:0] REG_DEADZONE = 2'd2;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

endpackage : sdz_pkg
`default_nettype wire

[sv/sdz_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdz_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module sdz_divider #(
    parameter int NUM_WIDTH = 32,
    parameter int DEN_WIDTH = 16,
    parameter int TAG_WIDTH = 8
) (
    input  wire logic                 i_clk,
    input  wire logic [NUM_WIDTH-1:0] i_num,
    input  wire logic [DEN_WIDTH-1:0] i_den,
    input  wire logic [TAG_WIDTH-1:0] i_tag,
    output logic      [NUM_WIDTH-1:0] o_quo,
    output logic      [TAG_WIDTH-1:0] o_tag
);

    logic [NUM_WIDTH-1:0] r_num [NUM_WIDTH+1];
    logic [DEN_WIDTH:0]   r_rem [NUM_WIDTH+1];
    logic [DEN_WIDTH-1:0] r_den [NUM_WIDTH+1];
    logic [TAG_WIDTH-1:0] r_tag [NUM_WIDTH+1];

    always_ff @(posedge i_clk) begin
        r_num[0] <= i_num;
        r_rem[0] <= '0;
        r_den[0] <= i_den;
        r_tag[0] <= i_tag;
    end

    for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
        logic [DEN_WIDTH+1:0] n_trial;
        logic                 n_ge;
        always_comb begin
            n_trial = {r_rem[s], r_num[s][NUM_WIDTH-1]};
            n_ge    = n_trial >= {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= n_ge ? (DEN_WIDTH+1)'(n_trial - {2'b00, r_den[s]})
                               : n_trial[DEN_WIDTH:0];
            r_num[s+1] <= {r_num[s][NUM_WIDTH-2:0], n_ge};
            r_den[s+1] <= r_den[s];
            r_tag[s+1] <= r_tag[s];
        end
    end

    assign o_quo = r_num[NUM_WIDTH];
    assign o_tag = r_tag[NUM_WIDTH];

endmodule : sdz_divider
`default_nettype wire

[sv/sdz_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdz_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module sdz_isqrt #(
    parameter int RES_WIDTH = 16,
    parameter int TAG_WIDTH = 8
) (
    input  wire logic                   i_clk,
    input  wire logic [2*RES_WIDTH-1:0] i_rad,
    input  wire logic [TAG_WIDTH-1:0]   i_tag,
    output logic      [RES_WIDTH-1:0]   o_root,
    output logic      [TAG_WIDTH-1:0]   o_tag
);

    logic [2*RES_WIDTH-1:0] r_rad  [RES_WIDTH+1];
    logic [RES_WIDTH+1:0]   r_rem  [RES_WIDTH+1];
    logic [RES_WIDTH-1:0]   r_root [RES_WIDTH+1];
    logic [TAG_WIDTH-1:0]   r_tag  [RES_WIDTH+1];

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= i_rad;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_tag[0]  <= i_tag;
    end

    for (genvar s = 0; s < RES_WIDTH; s++) begin : g_stage
        logic [RES_WIDTH+3:0] n_rem;
        logic [RES_WIDTH+3:0] n_trial;
        logic                 n_ge;
        always_comb begin
            n_rem   = {r_rem[s], r_rad[s][2*RES_WIDTH-1 -: 2]};
            n_trial = {2'b00, r_root[s], 2'b01};
            n_ge    = n_rem >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            r_rem[s+1]  <= n_ge ? (RES_WIDTH+2)'(n_rem - n_trial)
                                : n_rem[RES_WIDTH+1:0];
            r_root[s+1] <= {r_root[s][RES_WIDTH-2:0], n_ge};
            r_rad[s+1]  <= {r_rad[s][2*RES_WIDTH-3:0], 2'b00};
            r_tag[s+1]  <= r_tag[s];
        end
    end

    assign o_root = r_root[RES_WIDTH];
    assign o_tag  = r_tag[RES_WIDTH];

endmodule : sdz_isqrt
`default_nettype wire

[sv/sdz_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdz_lane
// per-axis linear transfer: deadzone removal, scaling and clamping
// ----------------------------------------------------------------------------
module sdz_lane #(
    parameter int MAG_WIDTH     = 16,
    parameter int FRACTION_BITS = 14,
    parameter int TAG_WIDTH     = 8
) (
    input  wire logic                   i_clk,
    input  wire logic [MAG_WIDTH-1:0]   i_mag,
    input  wire logic [MAG_WIDTH-2:0]   i_dz,
    input  wire logic [MAG_WIDTH-2:0]   i_fs,
    input  wire logic [TAG_WIDTH-1:0]   i_tag,
    output logic      [FRACTION_BITS:0] o_val,
    output logic      [TAG_WIDTH-1:0]   o_tag
);

    localparam int NW = MAG_WIDTH + FRACTION_BITS;
    localparam int KW = TAG_WIDTH + 2;
    localparam logic [FRACTION_BITS:0] UNITY = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

    logic                 n_zero, n_sat;
    logic [NW-1:0]        n_num;
    logic [MAG_WIDTH-2:0] n_den;
    logic [NW-1:0]        w_quo;
    logic [KW-1:0]        w_tag;

    always_comb begin
        n_zero = i_mag <= {1'b0, i_dz};
        n_sat  = i_fs <= i_dz;
        n_num  = NW'(MAG_WIDTH'(i_mag - {1'b0, i_dz})) << FRACTION_BITS;
        n_den  = i_fs - i_dz;
    end

    sdz_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(MAG_WIDTH-1), .TAG_WIDTH(KW)) u_div (
        .i_clk (i_clk),
        .i_num (n_num),
        .i_den (n_den),
        .i_tag ({i_tag, n_zero, n_sat}),
        .o_quo (w_quo),
        .o_tag (w_tag)
    );

    always_comb begin
        if (w_tag[1]) begin
            o_val = '0;
        end else if (w_tag[0] || w_quo > NW'(UNITY)) begin
            o_val = UNITY;
        end else begin
            o_val = w_quo[FRACTION_BITS:0];
        end
    end
    assign o_tag = w_tag[KW-1:2];

endmodule : sdz_lane
`default_nettype wire

[sv/stick_deadzone_scaler_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stick_deadzone_scaler_core
// deadzone removal and rescaling of one X/Y stick sample per cycle
// ----------------------------------------------------------------------------
// channel   ports                            transfer
// command   i_start, o_busy, i_stick_x/y     i_start && !o_busy
// result    o_valid, o_out_x/y               o_valid, one cycle
// config    i_cfg_we, i_cfg_index, i_cfg_data i_cfg_we
//
// one sample per cycle; o_busy is always low and results cannot be held off
// stages are the square register, root, lane divider, product register, merge
// divider and output register
// independent and none modes are delayed to the same latency
// reset clears the valid pipeline and restores register defaults
// ----------------------------------------------------------------------------
module stick_deadzone_scaler_core #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int FRACTION_BITS = 14
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_stick_x,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_stick_y,
    output logic                           o_valid,
    output logic      [FRACTION_BITS+1:0]  o_out_x,
    output logic      [FRACTION_BITS+1:0]  o_out_y,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [SAMPLE_WIDTH-2:0]   i_cfg_data
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int PW  = SW + FB + 1;
    localparam int NW  = SW + FB + 1;
    localparam int DL  = SW + FB + 1;
    localparam logic [FB:0] UNITY = (FB+1)'(1) << FB;

    logic [1:0]    r_mode;
    logic [SW-2:0] r_fs, r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sdz_pkg::MODE_INDEPENDENT;
            r_fs   <= (SW-1)'(32767);
            r_dz   <= (SW-1)'(7849);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sdz_pkg::REG_MODE:     r_mode <= i_cfg_data[1:0];
                sdz_pkg::REG_FULL:     r_fs   <= i_cfg_data;
                sdz_pkg::REG_DEADZONE: r_dz   <= i_cfg_data;
                default:               ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic          n_go;
    logic [SW-1:0] n_ax, n_ay;
    logic          n_circ;
    logic [SW-2:0] n_dz;

    always_comb begin
        n_go   = i_start;
        n_ax   = i_stick_x[SW-1] ? SW'(-i_stick_x) : i_stick_x;
        n_ay   = i_stick_y[SW-1] ? SW'(-i_stick_y) : i_stick_y;
        n_circ = r_mode == sdz_pkg::MODE_CIRCULAR;
        n_dz   = (r_mode == sdz_pkg::MODE_INDEPENDENT || n_circ) ? r_dz : '0;
    end

    // first stage: squares for the radius
    logic          r_v0, r_c0, r_sx0, r_sy0;
    logic [SW-1:0] r_ax0, r_ay0;
    logic [SW-2:0] r_dz0, r_fs0;
    logic [2*SW-1:0] r_sqx, r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= n_go;
        end
        r_c0  <= n_circ;
        r_sx0 <= i_stick_x[SW-1];
        r_sy0 <= i_stick_y[SW-1];
        r_ax0 <= n_ax;
        r_ay0 <= n_ay;
        r_dz0 <= n_dz;
        r_fs0 <= r_fs;
        r_sqx <= n_ax * n_ax;
        r_sqy <= n_ay * n_ay;
    end

    // radius: sum needs 2*SW+1 bits, root fits SW+1 bits
    localparam int RW = SW + 1;
    localparam int TW = 1 + 1 + 1 + 2*SW + 2*(SW-1);
    logic [2*RW-1:0] n_rad;
    logic [RW-1:0]   w_root;
    logic [TW-1:0]   w_qtag;
    assign n_rad = (2*RW)'(r_sqx) + (2*RW)'(r_sqy);

    sdz_isqrt #(.RES_WIDTH(RW), .TAG_WIDTH(TW)) u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (n_rad),
        .i_tag  ({r_c0, r_sx0, r_sy0, r_ax0, r_ay0, r_dz0, r_fs0}),
        .o_root (w_root),
        .o_tag  (w_qtag)
    );

    logic [RW-1:0] r_vq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= '0;
        end else begin
            r_vq <= {r_vq[RW-2:0], r_v0};
        end
    end

    logic          q_c, q_sx, q_sy;
    logic [SW-1:0] q_ax, q_ay;
    logic [SW-2:0] q_dz, q_fs;
    assign {q_c, q_sx, q_sy, q_ax, q_ay, q_dz, q_fs} = w_qtag;

    // lanes: x, y and radius each get the linear transfer
    localparam int LT = 1 + 1 + 1 + 2*SW + RW;
    logic [FB:0]   w_lx, w_ly, w_lr;
    logic [LT-1:0] w_ltag;
    logic [LT-1:0] w_ldum0, w_ldum1;

    sdz_lane #(.MAG_WIDTH(RW), .FRACTION_BITS(FB), .TAG_WIDTH(LT)) u_lane_r (
        .i_clk (i_clk),
        .i_mag (w_root),
        .i_dz  ({1'b0, q_dz}),
        .i_fs  ({1'b0, q_fs}),
        .i_tag ({q_c, q_sx, q_sy, q_ax, q_ay, w_root}),
        .o_val (w_lr),
        .o_tag (w_ltag)
    );
    sdz_lane #(.MAG_WIDTH(RW), .FRACTION_BITS(FB), .TAG_WIDTH(LT)) u_lane_x (
        .i_clk (i_clk),
        .i_mag ({1'b0, q_ax}),
        .i_dz  ({1'b0, q_dz}),
        .i_fs  ({1'b0, q_fs}),
        .i_tag ('0),
        .o_val (w_lx),
        .o_tag (w_ldum0)
    );
    sdz_lane #(.MAG_WIDTH(RW), .FRACTION_BITS(FB), .TAG_WIDTH(LT)) u_lane_y (
        .i_clk (i_clk),
        .i_mag ({1'b0, q_ay}),
        .i_dz  ({1'b0, q_dz}),
        .i_fs  ({1'b0, q_fs}),
        .i_tag (w_ldum0),
        .o_val (w_ly),
        .o_tag (w_ldum1)
    );

    logic [RW+FB+1:0] r_vl;
    logic             unused_tag;
    assign unused_tag = ^w_ldum1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl <= '0;
        end else begin
            r_vl <= {r_vl[RW+FB:0], r_vq[RW-1]};
        end
    end

    logic          l_c, l_sx, l_sy;
    logic [SW-1:0] l_ax, l_ay;
    logic [RW-1:0] l_r;
    assign {l_c, l_sx, l_sy, l_ax, l_ay, l_r} = w_ltag;

    // products for the circular scaling
    logic          r_v2, r_c2, r_sx2, r_sy2, r_z2;
    logic [FB:0]   r_lx2, r_ly2;
    logic [RW-1:0] r_r2;
    logic [PW-1:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_vl[RW+FB+1] & ~unused_tag | r_vl[RW+FB+1];
        end
        r_c2  <= l_c;
        r_sx2 <= l_sx;
        r_sy2 <= l_sy;
        r_z2  <= (w_lr == '0) || (l_r == '0);
        r_lx2 <= w_lx;
        r_ly2 <= w_ly;
        r_r2  <= l_r;
        r_px  <= PW'(l_ax) * PW'(w_lr);
        r_py  <= PW'(l_ay) * PW'(w_lr);
    end

    // merging: divide products by radius, with pass-through of lane results
    localparam int MT = 1 + 1 + 1 + 1 + 2*(FB+1);
    logic [NW-1:0] w_qx, w_qy;
    logic [MT-1:0] w_mtag, w_mdum;
    logic [RW-1:0] n_rden;
    assign n_rden = (r_r2 == '0) ? RW'(1) : r_r2;

    sdz_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(RW), .TAG_WIDTH(MT)) u_div_x (
        .i_clk (i_clk),
        .i_num (NW'(r_px)),
        .i_den (n_rden),
        .i_tag ({r_c2, r_sx2, r_sy2, r_z2, r_lx2, r_ly2}),
        .o_quo (w_qx),
        .o_tag (w_mtag)
    );
    sdz_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(RW), .TAG_WIDTH(MT)) u_div_y (
        .i_clk (i_clk),
        .i_num (NW'(r_py)),
        .i_den (n_rden),
        .i_tag ('0),
        .o_quo (w_qy),
        .o_tag (w_mdum)
    );

    logic [DL:0] r_vm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= '0;
        end else begin
            r_vm <= {r_vm[DL-1:0], r_v2 & ~(^w_mdum & 1'b0)};
        end
    end

    logic        m_c, m_sx, m_sy, m_z;
    logic [FB:0] m_lx, m_ly, n_mx, n_my;
    assign {m_c, m_sx, m_sy, m_z, m_lx, m_ly} = w_mtag;

    always_comb begin
        if (!m_c) begin
            n_mx = m_lx;
            n_my = m_ly;
        end else if (m_z) begin
            n_mx = '0;
            n_my = '0;
        end else begin
            n_mx = (w_qx > NW'(UNITY)) ? UNITY : w_qx[FB:0];
            n_my = (w_qy > NW'(UNITY)) ? UNITY : w_qy[FB:0];
        end
    end

    logic [FB+1:0] r_ox, r_oy;
    logic          r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_vm[DL];
        end
        r_ox <= m_sx ? (FB+2)'(-{1'b0, n_mx}) : {1'b0, n_mx};
        r_oy <= m_sy ? (FB+2)'(-{1'b0, n_my}) : {1'b0, n_my};
    end

    assign o_valid = r_ov;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;

endmodule : stick_deadzone_scaler_core
`default_nettype wire

[sv/sdz_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdz_checker
// port-level checks of the stick deadzone scaler
// ----------------------------------------------------------------------------
module sdz_checker #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int FRACTION_BITS = 14
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_start,
    input wire logic                     o_busy,
    input wire logic                     o_valid,
    input wire logic [FRACTION_BITS+1:0] o_out_x,
    input wire logic [FRACTION_BITS+1:0] o_out_y
);

    localparam logic signed [FRACTION_BITS+1:0] ONE =
        (FRACTION_BITS+2)'(1) << FRACTION_BITS;
    localparam int LATENCY = 3*SAMPLE_WIDTH + 2*FRACTION_BITS + 9;

    a_never_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_out_x) <= ONE && $signed(o_out_x) >= -ONE))
        else $error("out_x beyond unity");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_out_y) <= ONE && $signed(o_out_y) >= -ONE))
        else $error("out_y beyond unity");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_valid)
        else $error("no result at fixed latency after transfer");

endmodule : sdz_checker

bind stick_deadzone_scaler_core sdz_checker #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
) u_sdz_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_out_x (o_out_x),
    .o_out_y (o_out_y)
);
`default_nettype wire
